>>> rtl/core/polygon_edge_clipper_assert.svh
// Assertion macros for the polygon edge clipper.
`ifndef POLYGON_EDGE_CLIPPER_ASSERT_SVH
`define POLYGON_EDGE_CLIPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define PEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pec assertion failed");
`define PEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pec assertion failed");
`else
`define PEC_ASSERT_IMP(lbl, ante, cons)
`define PEC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/pec_pkg.sv
package pec_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int CROSS_W = 67;
  localparam int DEN_W = 68;
  localparam int NUM_W = 100;
  localparam int OFF_BITS = 40;
  localparam int Q_W = OFF_BITS + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 33;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_W - 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd4;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
  localparam logic [OP_W-1:0] OP_XM1     = 5'd2;
  localparam logic [OP_W-1:0] OP_XM2     = 5'd3;
  localparam logic [OP_W-1:0] OP_XSC     = 5'd4;
  localparam logic [OP_W-1:0] OP_XSO     = 5'd5;
  localparam logic [OP_W-1:0] OP_SET1    = 5'd6;
  localparam logic [OP_W-1:0] OP_SET2    = 5'd7;
  localparam logic [OP_W-1:0] OP_NM1     = 5'd8;
  localparam logic [OP_W-1:0] OP_NM2     = 5'd9;
  localparam logic [OP_W-1:0] OP_NM3     = 5'd10;
  localparam logic [OP_W-1:0] OP_DINIT   = 5'd11;
  localparam logic [OP_W-1:0] OP_DSTEP   = 5'd12;
  localparam logic [OP_W-1:0] OP_DRES    = 5'd13;
  localparam logic [OP_W-1:0] OP_CZERO   = 5'd14;
  localparam logic [OP_W-1:0] OP_EMIT_C  = 5'd15;
  localparam logic [OP_W-1:0] OP_EMIT_P1 = 5'd16;
  localparam logic [OP_W-1:0] OP_FIN     = 5'd17;

  localparam logic [1:0] PT_CUR = 2'd0;
  localparam logic [1:0] PT_PRV = 2'd1;
  localparam logic [1:0] PT_FST = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      pt;
    logic            axis;
  } pec_cmd_t;

  typedef struct packed {
    logic have_first;
    logic last;
    logic oin;
    logic din;
    logic den_zero;
    logic c_ne_p0;
    logic p1_ne_c;
    logic emit_ok;
    logic fin_ok;
  } pec_stat_t;

endpackage

>>> rtl/core/pec_datapath.sv
module pec_datapath import pec_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data,
  input  logic signed [COORD_W-1:0]   in_vert_x,
  input  logic signed [COORD_W-1:0]   in_vert_y,
  input  logic                        in_last_vertex,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic signed [COORD_W-1:0]   out_x,
  output logic signed [COORD_W-1:0]   out_y,
  output logic                        out_end_of_polygon,
  output logic                        out_empty_marker,
  input  pec_cmd_t                    cmd,
  output pec_stat_t                   stat
);

  localparam int LIM_W = COORD_W + FRAC_BITS;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic signed [COORD_W-1:0] org_x_r, org_y_r, dst_x_r, dst_y_r;
  logic [COORD_W-1:0]        thr_r;
  logic signed [COORD_W-1:0] vx_r, vy_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                      last_r, prev_in_r, have_first_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      psgn_r;
  logic signed [CROSS_W-1:0] t_r, sc_r, so_r, s0_r, s1_r;
  logic                      cin_r, fin_r, oin_r, din_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r, cx_r, cy_r;
  logic [NUM_W-1:0]          num_r;
  logic [REM_W-1:0]          rem_r;
  logic [Q_W-1:0]            nb_r, q_r;
  logic                      ovf_r;
  logic signed [COORD_W-1:0] pend_x_r, pend_y_r;
  logic                      pend_v_r;
  logic                      out_valid_r, out_eop_r, out_empty_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;

  logic signed [COORD_W-1:0] px, py;
  logic signed [32:0]        ax, ay, dvx, dvy, dc;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_sgn, mul_en;
  logic signed [CROSS_W-1:0] sprod, cross_new;
  logic [LIM_W-1:0]          lim;
  logic                      inside_new;
  logic signed [DEN_W-1:0]   den;
  logic [DEN_W-1:0]          dabs;
  logic [CROSS_W-1:0]        s0mag;
  logic [32:0]               dcmag;
  logic [REM_W-1:0]          trial, dabs_e;
  logic                      ge;
  logic [Q_W-1:0]            off;
  logic signed [42:0]        p0e, offe, res;
  logic signed [COORD_W-1:0] p0, res_sat;
  logic                      neg, out_free, emit, load_out;
  logic signed [COORD_W-1:0] ex, ey, lx, ly;
  logic                      leop, lempty;

  always_comb begin
    unique case (cmd.pt)
      PT_PRV: begin
        px = prev_x_r;
        py = prev_y_r;
      end
      PT_FST: begin
        px = first_x_r;
        py = first_y_r;
      end
      default: begin
        px = vx_r;
        py = vy_r;
      end
    endcase
  end

  assign ax  = 33'(dst_x_r) - 33'(org_x_r);
  assign ay  = 33'(dst_y_r) - 33'(org_y_r);
  assign dvx = 33'(px) - 33'(org_x_r);
  assign dvy = 33'(py) - 33'(org_y_r);

  assign den   = DEN_W'(s0_r) - DEN_W'(s1_r);
  assign dabs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign s0mag = s0_r[CROSS_W-1] ? CROSS_W'(-s0_r) : CROSS_W'(s0_r);
  assign dc    = cmd.axis ? (33'(y1_r) - 33'(y0_r)) : (33'(x1_r) - 33'(x0_r));
  assign dcmag = mag33(dc);
  assign p0    = cmd.axis ? y0_r : x0_r;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sgn = 1'b0;
    mul_en  = 1'b1;
    unique case (cmd.op)
      OP_XM1: begin
        mul_a   = {1'b0, mag33(ax)};
        mul_b   = mag33(dvy);
        mul_sgn = ax[32] ^ dvy[32];
      end
      OP_XM2: begin
        mul_a   = {1'b0, mag33(dvx)};
        mul_b   = mag33(ay);
        mul_sgn = dvx[32] ^ ay[32];
      end
      OP_NM1: begin
        mul_a = {1'b0, s0mag[32:0]};
        mul_b = dcmag;
      end
      OP_NM2: begin
        mul_a = s0mag[CROSS_W-1:33];
        mul_b = dcmag;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign sprod      = psgn_r ? -$signed(prod_r) : $signed(prod_r);
  assign cross_new  = t_r - sprod;
  assign lim        = {thr_r, {FRAC_BITS{1'b0}}};
  assign inside_new = !($signed(DEN_W'(cross_new)) > $signed({{(DEN_W-LIM_W){1'b0}}, lim}));

  assign dabs_e = {1'b0, dabs};
  assign trial  = {rem_r[REM_W-2:0], nb_r[Q_W-1]};
  assign ge     = trial >= dabs_e;

  assign off  = (ovf_r || (q_r > {1'b1, {OFF_BITS{1'b0}}})) ? {1'b1, {OFF_BITS{1'b0}}} : q_r;
  assign neg  = s0_r[CROSS_W-1] ^ dc[32] ^ den[DEN_W-1];
  assign p0e  = 43'(p0);
  assign offe = $signed({2'b00, off});
  assign res  = neg ? p0e - offe : p0e + offe;

  always_comb begin
    if (res[42:31] == {12{res[31]}}) begin
      res_sat = res[31:0];
    end else if (res[42]) begin
      res_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cmd.op == OP_EMIT_C) || (cmd.op == OP_EMIT_P1);
  assign ex       = (cmd.op == OP_EMIT_C) ? cx_r : x1_r;
  assign ey       = (cmd.op == OP_EMIT_C) ? cy_r : y1_r;

  always_comb begin
    load_out = 1'b0;
    lx       = pend_x_r;
    ly       = pend_y_r;
    leop     = 1'b0;
    lempty   = 1'b0;
    if (emit && pend_v_r) begin
      load_out = 1'b1;
    end else if (cmd.op == OP_FIN) begin
      if (pend_v_r) begin
        load_out = 1'b1;
        leop     = last_r;
      end else if (last_r) begin
        load_out = 1'b1;
        lx       = '0;
        ly       = '0;
        leop     = 1'b1;
        lempty   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r      <= '0;
      org_y_r      <= '0;
      dst_x_r      <= 32'sh0001_0000;
      dst_y_r      <= '0;
      thr_r        <= '0;
      prev_in_r    <= 1'b0;
      have_first_r <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORG_X: org_x_r <= cfg_data;
          REG_ORG_Y: org_y_r <= cfg_data;
          REG_DST_X: dst_x_r <= cfg_data;
          REG_DST_Y: dst_y_r <= cfg_data;
          REG_THR:   thr_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_FIN) begin
        prev_in_r    <= cin_r;
        have_first_r <= !last_r;
        pend_v_r     <= 1'b0;
      end else if (emit) begin
        pend_v_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
      psgn_r <= mul_sgn;
    end
    if (load_out) begin
      out_x_r     <= lx;
      out_y_r     <= ly;
      out_eop_r   <= leop;
      out_empty_r <= lempty;
    end
    if (emit) begin
      pend_x_r <= ex;
      pend_y_r <= ey;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        vx_r   <= in_vert_x;
        vy_r   <= in_vert_y;
        last_r <= in_last_vertex;
        if (!have_first_r) begin
          first_x_r <= in_vert_x;
          first_y_r <= in_vert_y;
        end
      end
      OP_XM2: t_r <= sprod;
      OP_XSC: begin
        sc_r  <= cross_new;
        cin_r <= inside_new;
      end
      OP_XSO: begin
        so_r  <= cross_new;
        fin_r <= inside_new;
      end
      OP_SET1: begin
        x0_r  <= prev_x_r;
        y0_r  <= prev_y_r;
        x1_r  <= vx_r;
        y1_r  <= vy_r;
        s0_r  <= so_r;
        s1_r  <= sc_r;
        oin_r <= prev_in_r;
        din_r <= cin_r;
      end
      OP_SET2: begin
        x0_r  <= vx_r;
        y0_r  <= vy_r;
        x1_r  <= first_x_r;
        y1_r  <= first_y_r;
        s0_r  <= sc_r;
        s1_r  <= so_r;
        oin_r <= cin_r;
        din_r <= fin_r;
      end
      OP_NM2: num_r <= NUM_W'(prod_r);
      OP_NM3: num_r <= num_r + {prod_r, 33'b0};
      OP_DINIT: begin
        rem_r <= REM_W'(num_r[NUM_W-1:Q_W]);
        nb_r  <= num_r[Q_W-1:0];
        q_r   <= '0;
        ovf_r <= DEN_W'(num_r[NUM_W-1:Q_W]) >= dabs;
      end
      OP_DSTEP: begin
        rem_r <= ge ? trial - dabs_e : trial;
        q_r   <= {q_r[Q_W-2:0], ge};
        nb_r  <= {nb_r[Q_W-2:0], 1'b0};
      end
      OP_DRES: begin
        if (cmd.axis) begin
          cy_r <= res_sat;
        end else begin
          cx_r <= res_sat;
        end
      end
      OP_CZERO: begin
        cx_r <= x0_r;
        cy_r <= y0_r;
      end
      OP_FIN: begin
        prev_x_r <= vx_r;
        prev_y_r <= vy_r;
      end
      default: ;
    endcase
  end

  assign stat.have_first = have_first_r;
  assign stat.last       = last_r;
  assign stat.oin        = oin_r;
  assign stat.din        = din_r;
  assign stat.den_zero   = (den == '0);
  assign stat.c_ne_p0    = (cx_r != x0_r) || (cy_r != y0_r);
  assign stat.p1_ne_c    = (x1_r != cx_r) || (y1_r != cy_r);
  assign stat.emit_ok    = !pend_v_r || out_free;
  assign stat.fin_ok     = !(pend_v_r || last_r) || out_free;

  assign out_valid          = out_valid_r;
  assign out_x              = out_x_r;
  assign out_y              = out_y_r;
  assign out_end_of_polygon = out_eop_r;
  assign out_empty_marker   = out_empty_r;

endmodule

>>> rtl/core/pec_ctrl.sv
`include "polygon_edge_clipper_assert.svh"

module pec_ctrl import pec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pec_stat_t stat,
  output pec_cmd_t  cmd
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_CUR1  = 5'd1;
  localparam logic [ST_W-1:0] S_CUR2  = 5'd2;
  localparam logic [ST_W-1:0] S_CUR3  = 5'd3;
  localparam logic [ST_W-1:0] S_PRV1  = 5'd4;
  localparam logic [ST_W-1:0] S_PRV2  = 5'd5;
  localparam logic [ST_W-1:0] S_PRV3  = 5'd6;
  localparam logic [ST_W-1:0] S_SET1  = 5'd7;
  localparam logic [ST_W-1:0] S_FST1  = 5'd8;
  localparam logic [ST_W-1:0] S_FST2  = 5'd9;
  localparam logic [ST_W-1:0] S_FST3  = 5'd10;
  localparam logic [ST_W-1:0] S_SET2  = 5'd11;
  localparam logic [ST_W-1:0] S_DEC   = 5'd12;
  localparam logic [ST_W-1:0] S_NM1   = 5'd13;
  localparam logic [ST_W-1:0] S_NM2   = 5'd14;
  localparam logic [ST_W-1:0] S_NM3   = 5'd15;
  localparam logic [ST_W-1:0] S_DINIT = 5'd16;
  localparam logic [ST_W-1:0] S_DSTEP = 5'd17;
  localparam logic [ST_W-1:0] S_DRES  = 5'd18;
  localparam logic [ST_W-1:0] S_CZERO = 5'd19;
  localparam logic [ST_W-1:0] S_POST  = 5'd20;
  localparam logic [ST_W-1:0] S_EMC   = 5'd21;
  localparam logic [ST_W-1:0] S_EMP1  = 5'd22;
  localparam logic [ST_W-1:0] S_FIN   = 5'd23;

  logic [ST_W-1:0]  state_r, state_nxt, after_pair;
  logic             pair_r, pair_nxt, axis_r, axis_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign after_pair = (!pair_r && stat.last) ? S_FST1 : S_FIN;

  always_comb begin
    state_nxt = state_r;
    pair_nxt  = pair_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NOP;
    cmd.pt    = PT_CUR;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CUR1;
        end
      end
      S_CUR1: begin
        cmd.op    = OP_XM1;
        state_nxt = S_CUR2;
      end
      S_CUR2: begin
        cmd.op    = OP_XM2;
        state_nxt = S_CUR3;
      end
      S_CUR3: begin
        cmd.op = OP_XSC;
        if (stat.have_first) begin
          state_nxt = S_PRV1;
        end else if (stat.last) begin
          state_nxt = S_FST1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PRV1: begin
        cmd.op    = OP_XM1;
        cmd.pt    = PT_PRV;
        state_nxt = S_PRV2;
      end
      S_PRV2: begin
        cmd.op    = OP_XM2;
        cmd.pt    = PT_PRV;
        state_nxt = S_PRV3;
      end
      S_PRV3: begin
        cmd.op    = OP_XSO;
        state_nxt = S_SET1;
      end
      S_SET1: begin
        cmd.op    = OP_SET1;
        pair_nxt  = 1'b0;
        state_nxt = S_DEC;
      end
      S_FST1: begin
        cmd.op    = OP_XM1;
        cmd.pt    = PT_FST;
        state_nxt = S_FST2;
      end
      S_FST2: begin
        cmd.op    = OP_XM2;
        cmd.pt    = PT_FST;
        state_nxt = S_FST3;
      end
      S_FST3: begin
        cmd.op    = OP_XSO;
        state_nxt = S_SET2;
      end
      S_SET2: begin
        cmd.op    = OP_SET2;
        pair_nxt  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (stat.oin && stat.din) begin
          state_nxt = S_EMP1;
        end else if (!stat.oin && !stat.din) begin
          state_nxt = after_pair;
        end else if (stat.den_zero) begin
          state_nxt = S_CZERO;
        end else begin
          axis_nxt  = 1'b0;
          state_nxt = S_NM1;
        end
      end
      S_NM1: begin
        cmd.op    = OP_NM1;
        state_nxt = S_NM2;
      end
      S_NM2: begin
        cmd.op    = OP_NM2;
        state_nxt = S_NM3;
      end
      S_NM3: begin
        cmd.op    = OP_NM3;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = OP_DINIT;
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_DRES;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRES: begin
        cmd.op = OP_DRES;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_NM1;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_CZERO: begin
        cmd.op    = OP_CZERO;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (stat.oin && !stat.c_ne_p0) begin
          state_nxt = after_pair;
        end else begin
          state_nxt = S_EMC;
        end
      end
      S_EMC: begin
        if (stat.emit_ok) begin
          cmd.op = OP_EMIT_C;
          if (!stat.oin && stat.p1_ne_c) begin
            state_nxt = S_EMP1;
          end else begin
            state_nxt = after_pair;
          end
        end
      end
      S_EMP1: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_EMIT_P1;
          state_nxt = after_pair;
        end
      end
      S_FIN: begin
        if (stat.fin_ok) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pair_r  <= 1'b0;
      axis_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pair_r  <= pair_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `PEC_ASSERT_IMP(a_emit_ok, (cmd.op == OP_EMIT_C) || (cmd.op == OP_EMIT_P1), stat.emit_ok)
  `PEC_ASSERT_IMP(a_fin_ok, cmd.op == OP_FIN, stat.fin_ok)
  `PEC_ASSERT_NXT(a_accept, in_valid && !in_stall, state_r == S_CUR1)
  `PEC_ASSERT_IMP(a_div_cnt, state_r == S_DSTEP, cnt_r <= DIV_LAST)

endmodule

>>> rtl/core/polygon_edge_clipper.sv
// Channel  Handshake          Payload
// in       in_valid/in_stall  in_vert_x, in_vert_y, in_last_vertex
// out      out_valid/out_stall out_x, out_y, out_end_of_polygon, out_empty_marker
// cfg      cfg_we             cfg_index, cfg_data
// One vertex at a time, whether it is only stored or forms a pair with no crossing.
// A crossing runs two 41-step shift-subtract divisions on one divider.
// A closing vertex after the first runs two pairs.
// Synchronous active-low reset clears the controller and output valid, and resets the edge registers.
// A stalled output holds the block before its next result beat.
module polygon_edge_clipper import pec_pkg::*; #(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_vert_x,
  input  logic signed [COORD_W-1:0] in_vert_y,
  input  logic                      in_last_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_end_of_polygon,
  output logic                      out_empty_marker,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data
);

  pec_cmd_t  cmd;
  pec_stat_t stat;

  pec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pec_datapath #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_vert_x          (in_vert_x),
    .in_vert_y          (in_vert_y),
    .in_last_vertex     (in_last_vertex),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_end_of_polygon (out_end_of_polygon),
    .out_empty_marker   (out_empty_marker),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule
